>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the frame slot manager RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define FSLOT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication.
`define FSLOT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    `FSLOT_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

>>> rtl/fslot_pkg.sv
// ----------------------------------------------------------------------------
// fslot_pkg
// Types and constants of the frame slot manager.
// ----------------------------------------------------------------------------
package fslot_pkg;

    localparam int ACTION_W = 3;
    localparam int FDIM_W   = 16;
    localparam int SCALE_W  = 12;
    localparam int NUM_W    = 32;
    localparam int INDEX_W  = 4;

    typedef logic [NUM_W-1:0] t_num;

    localparam t_num NUM_MAX = {NUM_W{1'b1}};
    localparam t_num NUM_ONE = t_num'(1);

    typedef enum logic [ACTION_W-1:0] {
        ACT_SUBMIT  = 3'd0,
        ACT_ACQUIRE = 3'd1,
        ACT_RELEASE = 3'd2,
        ACT_QUERY   = 3'd3,
        ACT_CLEAR   = 3'd4
    } t_action;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
    } t_pick;

endpackage

>>> rtl/fslot_pick.sv
// ----------------------------------------------------------------------------
// fslot_pick
// Comparator tree: largest number among candidate slots, lowest index on ties.
// ----------------------------------------------------------------------------
module fslot_pick import fslot_pkg::*; #(
    parameter int N = 3
) (
    input  logic [N-1:0] i_cand,
    input  t_num         i_num [N],
    output t_pick        o_pick
);

    localparam int IW    = $clog2(N);
    localparam int LEAFS = 1 << IW;
    localparam int NODES = 2 * LEAFS - 1;

    logic          w_v   [NODES];
    t_num          w_num [NODES];
    logic [IW-1:0] w_idx [NODES];

    genvar g;

    generate
        for (g = 0; g < LEAFS; g++) begin : g_leaf
            if (g < N) begin : g_real
                assign w_v[LEAFS-1+g]   = i_cand[g];
                assign w_num[LEAFS-1+g] = i_num[g];
            end else begin : g_pad
                assign w_v[LEAFS-1+g]   = 1'b0;
                assign w_num[LEAFS-1+g] = '0;
            end
            assign w_idx[LEAFS-1+g] = IW'(g);
        end

        for (g = 0; g < LEAFS - 1; g++) begin : g_node
            logic w_take_r;
            // right child wins only when strictly larger
            assign w_take_r = w_v[2*g+2] &&
                              (!w_v[2*g+1] || (w_num[2*g+2] > w_num[2*g+1]));
            assign w_v[g]   = w_v[2*g+1] || w_v[2*g+2];
            assign w_num[g] = w_take_r ? w_num[2*g+2] : w_num[2*g+1];
            assign w_idx[g] = w_take_r ? w_idx[2*g+2] : w_idx[2*g+1];
        end
    endgenerate

    assign o_pick.found = w_v[0];
    assign o_pick.index = w_v[0] ? INDEX_W'(w_idx[0]) : '0;

endmodule

>>> rtl/frame_slot_manager_core.sv
// ----------------------------------------------------------------------------
// frame_slot_manager_core
// Bookkeeping for a small set of frame buffer slots (submit, acquire,
// release, query, clear).
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid / o_stall carries one request item: action and
//   the frame key (width, height, scale). Output channel o_valid / i_stall
//   returns exactly one item per request: o_found and o_slot_index.
//   An item is captured in the input register, then resolved against the
//   slot state by one pass of compare logic; state and the result register
//   update together when the item leaves the input register. Throughput
//   is one item per cycle while i_stall is low; the slot comparator tree
//   has depth ceil(log2(SLOTS)) of 32-bit compares.
//   While i_stall holds a pending result, one more item is taken into the
//   input register, then o_stall rises until the result is taken.
//   Reset empties all slots, drops every hold and sets the sequence counter
//   to one; slot keys are not reset and are only compared in filled slots.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frame_slot_manager_core import fslot_pkg::*; #(
    parameter int SLOTS = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [ACTION_W-1:0] i_action,
    input  logic [FDIM_W-1:0]  i_frame_width,
    input  logic [FDIM_W-1:0]  i_frame_height,
    input  logic [SCALE_W-1:0] i_pixel_scale,
    output logic               o_valid,
    input  logic               i_stall,
    output logic               o_found,
    output logic [INDEX_W-1:0] o_slot_index
);

    localparam int IW = $clog2(SLOTS);

    logic                r_in_valid;
    logic [ACTION_W-1:0] r_in_action;
    logic [FDIM_W-1:0]   r_in_width;
    logic [FDIM_W-1:0]   r_in_height;
    logic [SCALE_W-1:0]  r_in_scale;

    t_num                r_num   [SLOTS];
    logic [SLOTS-1:0]    r_held;
    logic [FDIM_W-1:0]   r_width  [SLOTS];
    logic [FDIM_W-1:0]   r_height [SLOTS];
    logic [SCALE_W-1:0]  r_scale  [SLOTS];
    t_num                r_next;

    logic                r_out_valid;
    logic                r_out_found;
    logic [INDEX_W-1:0]  r_out_index;

    t_num                n_num [SLOTS];
    logic [SLOTS-1:0]    n_held;
    t_num                n_next;

    logic                w_accept;
    logic                w_adv;
    logic [SLOTS-1:0]    w_empty;
    logic [SLOTS-1:0]    w_free;
    logic [SLOTS-1:0]    w_match;
    t_num                w_inv_num [SLOTS];
    logic [IW-1:0]       w_free_idx;
    logic [IW-1:0]       w_rel_idx;
    t_pick               w_old;
    t_pick               w_new;
    logic                w_key_we;
    logic [IW-1:0]       w_key_idx;
    logic                w_res_found;
    logic [INDEX_W-1:0]  w_res_index;

    assign w_adv    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall  = r_in_valid && r_out_valid && i_stall;
    assign w_accept = i_valid && !o_stall;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            w_empty[i]   = (r_num[i] == '0);
            w_free[i]    = w_empty[i] && !r_held[i];
            w_inv_num[i] = ~r_num[i];
            w_match[i]   = !w_empty[i] && !r_held[i] &&
                           (r_width[i] == r_in_width) &&
                           (r_height[i] == r_in_height) &&
                           (r_scale[i] == r_in_scale);
        end
    end

    always_comb begin
        w_free_idx = '0;
        w_rel_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (w_free[i]) begin
                w_free_idx = IW'(i);
            end
            if (r_held[i]) begin
                w_rel_idx = IW'(i);
            end
        end
    end

    // oldest unheld slot: max of inverted numbers
    fslot_pick #(.N(SLOTS)) u_pick_old (
        .i_cand (~r_held),
        .i_num  (w_inv_num),
        .o_pick (w_old)
    );

    // newest matching slot
    fslot_pick #(.N(SLOTS)) u_pick_new (
        .i_cand (w_match),
        .i_num  (r_num),
        .o_pick (w_new)
    );

    always_comb begin
        n_num       = r_num;
        n_held      = r_held;
        n_next      = r_next;
        w_key_we    = 1'b0;
        w_key_idx   = '0;
        w_res_found = 1'b0;
        w_res_index = '0;
        case (r_in_action)
            ACT_SUBMIT: begin
                if ((|w_free) || w_old.found) begin
                    w_key_we  = 1'b1;
                    w_key_idx = (|w_free) ? w_free_idx : w_old.index[IW-1:0];
                    n_num[w_key_idx] = r_next;
                    if (r_next != NUM_MAX) begin
                        n_next = r_next + NUM_ONE;
                    end
                    w_res_found = 1'b1;
                    w_res_index = INDEX_W'(w_key_idx);
                end
            end
            ACT_ACQUIRE: begin
                if (w_new.found) begin
                    n_held[w_new.index[IW-1:0]] = 1'b1;
                end
                w_res_found = w_new.found;
                w_res_index = w_new.index;
            end
            ACT_RELEASE: begin
                if (|r_held) begin
                    n_held[w_rel_idx] = 1'b0;
                    w_res_found = 1'b1;
                    w_res_index = INDEX_W'(w_rel_idx);
                end
            end
            ACT_QUERY: begin
                w_res_found = |w_match;
            end
            ACT_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) begin
                    n_num[i] = '0;
                end
                n_held = '0;
                n_next = NUM_ONE;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_action <= i_action;
            r_in_width  <= i_frame_width;
            r_in_height <= i_frame_height;
            r_in_scale  <= i_pixel_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_num[i] <= '0;
            end
            r_held <= '0;
            r_next <= NUM_ONE;
        end else if (w_adv) begin
            r_num  <= n_num;
            r_held <= n_held;
            r_next <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_key_we) begin
            r_width[w_key_idx]  <= r_in_width;
            r_height[w_key_idx] <= r_in_height;
            r_scale[w_key_idx]  <= r_in_scale;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_found <= w_res_found;
            r_out_index <= w_res_index;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_found      = r_out_found;
    assign o_slot_index = r_out_index;

    `FSLOT_ASSERT(a_held_not_empty, i_clk, i_rst_n, (r_held & w_empty) == '0, "held slot is empty")
    `FSLOT_ASSERT(a_next_nonzero, i_clk, i_rst_n, r_next != '0, "sequence counter reached zero")
    `FSLOT_ASSERT(a_clear_empties, i_clk, i_rst_n, (w_adv && r_in_action == ACT_CLEAR) |=> (r_held == '0 && r_next == NUM_ONE), "clear left state behind")
    `FSLOT_ASSERT_IMP(a_submit_found, i_clk, i_rst_n, w_adv && r_in_action == ACT_SUBMIT && r_held != {SLOTS{1'b1}}, w_res_found, "submit missed an unheld slot")

endmodule
